// ----- sv/assert_macros.svh -----
// Assertion helpers used by the RTL file i2cm_fsm.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property that must never hold on any rising clock edge outside reset.
`define ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error(msg);

`endif

// ----- sv/i2cm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_BEGIN_WRITE = 2'd1;
  localparam logic [1:0] OP_BEGIN_READ  = 2'd2;
  localparam logic [1:0] OP_TX_BYTE     = 2'd3;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] LSB_MASK = 8'h01;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_SCL  = 4'd1,
    PH_START_SDA  = 4'd2,
    PH_START_HOLD = 4'd3,
    PH_TX_RISE    = 4'd4,
    PH_TX_FALL    = 4'd5,
    PH_ACK_RISE   = 4'd6,
    PH_ACK_FALL   = 4'd7,
    PH_WAIT_BYTE  = 4'd8,
    PH_RX_RISE    = 4'd9,
    PH_RX_FALL    = 4'd10,
    PH_MACK_RISE  = 4'd11,
    PH_MACK_FALL  = 4'd12,
    PH_STOP_RISE  = 4'd13,
    PH_STOP_END   = 4'd14
  } phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] slave_address;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       need_byte;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       slave_ack;
    logic       frame_done;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/i2cm_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2cm_fsm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_en_i,
  input  wire i2cm_pkg::in_item_t  item_i,
  output i2cm_pkg::out_item_t      result_o
);
  import i2cm_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       read_frame_q, read_frame_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  logic [7:0] rx_out;
  logic       rx_ok;
  logic       ack_out;
  logic       done;
  logic [3:0] bit_cnt_inc;
  logic [7:0] shift_tx_nxt;
  logic [7:0] shift_rx_nxt;
  logic [7:0] bytes_dec;

  assign bit_cnt_inc  = bit_cnt_q + 4'd1;
  assign shift_tx_nxt = {shift_q[6:0], 1'b0};
  assign shift_rx_nxt = {shift_q[6:0], item_i.sda_sample & LSB_MASK[0]};
  assign bytes_dec    = bytes_left_q - 8'd1;

  // Next-state step for one item
  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    bytes_left_d = bytes_left_q;
    read_frame_d = read_frame_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    rx_out       = 8'h00;
    rx_ok        = 1'b0;
    ack_out      = 1'b0;
    done         = 1'b0;
    case (item_i.operation)
      OP_BEGIN_WRITE, OP_BEGIN_READ: begin
        if (phase_q == PH_IDLE) begin
          read_frame_d = (item_i.operation == OP_BEGIN_READ);
          shift_d      = {item_i.slave_address, item_i.operation == OP_BEGIN_READ};
          bytes_left_d = item_i.byte_count;
          bit_cnt_d    = 4'd0;
          scl_d        = 1'b0;
          sda_d        = 1'b0;
          phase_d      = PH_START_SCL;
        end
      end
      OP_TX_BYTE: begin
        if (phase_q == PH_WAIT_BYTE) begin
          shift_d      = item_i.tx_byte;
          bytes_left_d = bytes_dec;
          bit_cnt_d    = 4'd0;
          sda_d        = ~|(item_i.tx_byte & MSB_MASK);
          phase_d      = PH_TX_RISE;
        end
      end
      default: begin
        case (phase_q)
          PH_START_SCL: begin
            scl_d   = 1'b0;
            phase_d = PH_START_SDA;
          end
          PH_START_SDA: begin
            sda_d   = 1'b1;
            phase_d = PH_START_HOLD;
          end
          PH_START_HOLD: begin
            scl_d     = 1'b1;
            bit_cnt_d = 4'd0;
            sda_d     = ~|(shift_q & MSB_MASK);
            phase_d   = PH_TX_RISE;
          end
          PH_TX_RISE: begin
            scl_d   = 1'b0;
            phase_d = PH_TX_FALL;
          end
          PH_TX_FALL: begin
            scl_d     = 1'b1;
            shift_d   = shift_tx_nxt;
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= BITS_PER_BYTE) begin
              sda_d   = 1'b0;
              phase_d = PH_ACK_RISE;
            end else begin
              sda_d   = ~|(shift_tx_nxt & MSB_MASK);
              phase_d = PH_TX_RISE;
            end
          end
          PH_ACK_RISE: begin
            scl_d   = 1'b0;
            phase_d = PH_ACK_FALL;
          end
          PH_ACK_FALL: begin
            ack_out = item_i.sda_sample;
            scl_d   = 1'b1;
            if (bytes_left_q == 8'd0) begin
              sda_d   = 1'b1;
              phase_d = PH_STOP_RISE;
            end else if (read_frame_q) begin
              sda_d     = 1'b0;
              bit_cnt_d = 4'd0;
              shift_d   = 8'h00;
              phase_d   = PH_RX_RISE;
            end else begin
              phase_d = PH_WAIT_BYTE;
            end
          end
          PH_WAIT_BYTE: begin
            // SCL held low until the next transmit byte arrives
            phase_d = PH_WAIT_BYTE;
          end
          PH_RX_RISE: begin
            scl_d   = 1'b0;
            phase_d = PH_RX_FALL;
          end
          PH_RX_FALL: begin
            shift_d   = shift_rx_nxt;
            scl_d     = 1'b1;
            bit_cnt_d = bit_cnt_inc;
            if (bit_cnt_inc >= BITS_PER_BYTE) begin
              rx_out       = shift_rx_nxt;
              rx_ok        = 1'b1;
              bytes_left_d = bytes_dec;
              // ack while more bytes follow, nack the last
              sda_d        = (bytes_dec != 8'd0);
              phase_d      = PH_MACK_RISE;
            end else begin
              phase_d = PH_RX_RISE;
            end
          end
          PH_MACK_RISE: begin
            scl_d   = 1'b0;
            phase_d = PH_MACK_FALL;
          end
          PH_MACK_FALL: begin
            scl_d = 1'b1;
            if (bytes_left_q == 8'd0) begin
              sda_d   = 1'b1;
              phase_d = PH_STOP_RISE;
            end else begin
              sda_d     = 1'b0;
              bit_cnt_d = 4'd0;
              shift_d   = 8'h00;
              phase_d   = PH_RX_RISE;
            end
          end
          PH_STOP_RISE: begin
            scl_d   = 1'b0;
            phase_d = PH_STOP_END;
          end
          PH_STOP_END: begin
            sda_d   = 1'b0;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    endcase
  end

  // Result fields reflect the state after the item
  always_comb begin
    result_o.scl_low    = scl_d;
    result_o.sda_low    = sda_d;
    result_o.busy_res   = (phase_d != PH_IDLE);
    result_o.need_byte  = (phase_d == PH_WAIT_BYTE);
    result_o.rx_byte    = rx_out;
    result_o.rx_valid   = rx_ok;
    result_o.slave_ack  = ack_out;
    result_o.frame_done = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= 4'd0;
      shift_q      <= 8'h00;
      bytes_left_q <= 8'h00;
      read_frame_q <= 1'b0;
      scl_q        <= 1'b0;
      sda_q        <= 1'b0;
    end else if (step_en_i) begin
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      bytes_left_q <= bytes_left_d;
      read_frame_q <= read_frame_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
    end
  end

  `ASSERT_CLKD(a_need_implies_busy, step_en_i && result_o.need_byte |-> result_o.busy_res,
    "need_byte raised outside a frame")
  `ASSERT_CLKD(a_done_to_idle, step_en_i && result_o.frame_done |=> phase_q == PH_IDLE,
    "frame_done without return to idle")
  `ASSERT_CLKD(a_wait_holds_scl, step_en_i && result_o.need_byte |=> scl_q,
    "SCL released while waiting for a transmit byte")
  `ASSERT_NEVER(a_rx_ack_excl, step_en_i && result_o.rx_valid && result_o.slave_ack,
    "rx_valid and slave_ack on the same item")

endmodule

`default_nettype wire

// ----- sv/i2c_master_frame_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// I2C master frame engine. One item is taken every clock cycle unless the
// output stalls; the item sits in the input register, then the bit-level
// state step writes its result into the result register once that register
// is free, and the result is presented on the output from there.
// The state step handles start, address, data, ack and stop half-bit
// phases; a tick item is one half-bit period. Output stalls back up
// through the result and input registers.
module i2c_master_frame_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire i2cm_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output i2cm_pkg::out_item_t      out_item_o
);
  import i2cm_pkg::*;

  in_item_t  in_item_q;
  logic      in_valid_q;
  out_item_t out_item_q;
  logic      out_valid_q;
  out_item_t step_result;
  logic      step_en;

  // item in the input register moves on when the result register is free
  assign step_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  i2cm_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (in_item_q),
    .result_o  (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_item_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
